>>> rtl/tlr_pkg.sv
package tlr_pkg;

  // Fixed field widths
  localparam int BYTE_W    = 8;
  localparam int COL_W     = 8;
  localparam int LEN_W     = 5;
  localparam int OPCODE_W  = 2;
  localparam int CFG_IDX_W = 2;

  // Operation codes
  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE_CHAR = 2'd0,
    OP_SET_BLINK  = 2'd1,
    OP_REFRESH    = 2'd2,
    OP_CLEAR      = 2'd3
  } opcode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW0_LENGTH = 2'd0,
    REG_ROW1_LENGTH = 2'd1,
    REG_ROW0_SCROLL = 2'd2,
    REG_ROW1_SCROLL = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COL_MOD,
    ST_BLINK_RD,
    ST_ACK,
    ST_CLEAR_ACK,
    ST_OFS_MOD,
    ST_ROW_CMD,
    ST_ROW_CHARS
  } state_t;

  // Display bytes
  localparam logic [BYTE_W-1:0] CMD_CLEAR  = 8'h01;
  localparam logic [BYTE_W-1:0] CMD_ROW0   = 8'h80;
  localparam logic [BYTE_W-1:0] CMD_ROW1   = 8'hC0;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [LEN_W-1:0] LEN_RESET = 5'd16;

endpackage

>>> rtl/tlr_if.sv
// Request channel: one operation per transfer
interface tlr_req_if;
  import tlr_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic                row_sel;
  logic [COL_W-1:0]    column;
  logic [BYTE_W-1:0]   char_code;
  logic                blink_on;

  modport source (output valid, opcode, row_sel, column, char_code, blink_on,
                  input ready);
  modport sink (input valid, opcode, row_sel, column, char_code, blink_on,
                output ready);
endinterface

// Response channel: one display byte or acknowledge per transfer
interface tlr_rsp_if;
  import tlr_pkg::*;

  logic              valid;
  logic              ready;
  logic              is_data;
  logic [BYTE_W-1:0] out_byte;
  logic              prev_blink;
  logic              emit_valid;
  logic              last;

  modport source (output valid, is_data, out_byte, prev_blink, emit_valid, last,
                  input ready);
  modport sink (input valid, is_data, out_byte, prev_blink, emit_valid, last,
                output ready);
endinterface

>>> rtl/tlr_ram.sv
module tlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds without re
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/tlr_mod.sv
module tlr_mod #(
  parameter int DIVISOR_W = 5
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tlr_pkg::COL_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]       divisor,
  output logic                       done,
  output logic [DIVISOR_W-1:0]       remainder
);
  import tlr_pkg::*;

  localparam int STEPS = COL_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [COL_W-1:0]     dvd;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] rem;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   rem_next;

  // Restoring remainder, one dividend bit per cycle (MSB first)
  always_comb begin
    trial = {rem, dvd[COL_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = trial - {1'b0, dvs};
    end else begin
      rem_next = trial;
    end
  end

  // Operands are captured at start; the divisor is held and the dividend shifted out during the reduction
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
        cnt  <= CNT_W'(STEPS);
        busy <= 1'b1;
      end else if (busy) begin
        dvd <= dvd << 1;
        rem <= rem_next[DIVISOR_W-1:0];
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem;

endmodule

>>> rtl/text_line_refresh_with_blink_scroll.sv
// Write char and set blink acknowledge once the column is reduced, set blink after
// a blink read. Clear needs no reduction. Refresh tick: len0 + len1 + 2 bytes, one
// per cycle once a row streams and the receiver is ready, after the 8-step bit-serial
// remainder unit reduces that row's offset; one operation is in flight at a time.
// Reset (synchronous, rst high) clears the per-cell valid bits, so every cell reads
// as a space with no blink at once; no memory sweep is needed.
module text_line_refresh_with_blink_scroll #(
  parameter int MAX_ROW_CELLS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  tlr_req_if.sink                         req,
  tlr_rsp_if.source                       rsp,
  input  logic                            wr_en,
  input  logic [tlr_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [tlr_pkg::LEN_W-1:0]       wr_data
);
  import tlr_pkg::*;

  localparam int LW    = $clog2(MAX_ROW_CELLS + 1);
  localparam int CW    = (MAX_ROW_CELLS > 1) ? $clog2(MAX_ROW_CELLS) : 1;
  localparam int DEPTH = 2 * MAX_ROW_CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_ROW_CELLS);

  // Clamp a length register to 1..MAX_ROW_CELLS
  function automatic logic [LW-1:0] eff_len(input logic [LEN_W-1:0] n);
    if (n == '0) begin
      return LW'(1);
    end else if (n > MAX_LEN) begin
      return LW'(MAX_ROW_CELLS);
    end else begin
      return LW'(n);
    end
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic r, input logic [CW-1:0] c);
    return (r ? AW'(MAX_ROW_CELLS) : AW'(0)) + AW'(c);
  endfunction

  // Next cell index, wrapping at the row length
  function automatic logic [CW-1:0] next_cell(input logic [CW-1:0] c,
                                              input logic [LW-1:0] n);
    logic [LW:0] inc;
    inc = (LW+1)'(c) + (LW+1)'(1);
    return (inc == (LW+1)'(n)) ? '0 : CW'(inc);
  endfunction

  // Configuration registers
  logic [LEN_W-1:0] row0_length;
  logic [LEN_W-1:0] row1_length;
  logic             row0_scroll_enable;
  logic             row1_scroll_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      row0_length        <= LEN_RESET;
      row1_length        <= LEN_RESET;
      row0_scroll_enable <= 1'b0;
      row1_scroll_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_ROW0_LENGTH: row0_length        <= wr_data;
        REG_ROW1_LENGTH: row1_length        <= wr_data;
        REG_ROW0_SCROLL: row0_scroll_enable <= wr_data[0];
        REG_ROW1_SCROLL: row1_scroll_enable <= wr_data[0];
      endcase
    end
  end

  logic [LW-1:0] len0;
  logic [LW-1:0] len1;
  assign len0 = eff_len(row0_length);
  assign len1 = eff_len(row1_length);

  // Control and datapath registers
  state_t            state;
  state_t            state_next;
  opcode_t           op;
  logic              row;
  logic [BYTE_W-1:0] code;
  logic              blink_val;
  logic              prev_q;
  logic              rf_row;
  logic [CW-1:0]     idx;
  logic [LW-1:0]     left;
  logic              pend;
  logic [1:0]        phase;
  logic [CW-1:0]     offset0;
  logic [CW-1:0]     offset1;
  logic [DEPTH-1:0]  vchar;
  logic [DEPTH-1:0]  vblink;
  logic              cvld_q;
  logic              bvld_q;

  // Output register
  logic              out_valid;
  logic              out_is_data;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_prev;
  logic              out_emit;
  logic              out_last;

  // Remainder unit
  logic              mod_start;
  logic [COL_W-1:0]  mod_dividend;
  logic [LW-1:0]     mod_divisor;
  logic              mod_done;
  logic [LW-1:0]     mod_rem;

  tlr_mod #(.DIVISOR_W(LW)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (mod_dividend),
    .divisor   (mod_divisor),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // Character and blink memories
  logic              c_we;
  logic              b_we;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [BYTE_W-1:0] c_rdata;
  logic              b_rdata;
  logic [AW-1:0]     col_addr;
  logic [AW-1:0]     chr_addr;

  tlr_ram #(.WIDTH(BYTE_W), .DEPTH(DEPTH)) u_char_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (col_addr),
    .wdata (code),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (c_rdata)
  );

  tlr_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_blink_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (col_addr),
    .wdata (blink_val),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (b_rdata)
  );

  // Shared helper terms
  logic              can_load;
  logic              accept;
  logic              emit_chr;
  logic [LW-1:0]     cur_len;
  logic              cur_scroll;
  logic [BYTE_W-1:0] shown;

  assign can_load   = !out_valid || rsp.ready;
  assign accept     = (state == ST_IDLE) && req.valid;
  assign emit_chr   = (state == ST_ROW_CHARS) && pend && can_load;
  assign cur_len    = rf_row ? len1 : len0;
  assign cur_scroll = rf_row ? row1_scroll_enable : row0_scroll_enable;
  assign col_addr   = cell_addr(row, mod_rem[CW-1:0]);
  assign chr_addr   = cell_addr(rf_row, idx);
  assign req.ready  = (state == ST_IDLE);

  // Displayed character: unwritten cells are spaces, blinking cells blank off phase 0
  always_comb begin
    shown = cvld_q ? c_rdata : CHAR_SPACE;
    if (bvld_q && b_rdata && (phase != 2'd0)) begin
      shown = CHAR_SPACE;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          unique case (opcode_t'(req.opcode))
            OP_WRITE_CHAR, OP_SET_BLINK: state_next = ST_COL_MOD;
            OP_REFRESH:                  state_next = ST_OFS_MOD;
            OP_CLEAR:                    state_next = ST_CLEAR_ACK;
          endcase
        end
      end
      ST_COL_MOD: begin
        if (mod_done) begin
          state_next = (op == OP_WRITE_CHAR) ? ST_ACK : ST_BLINK_RD;
        end
      end
      ST_BLINK_RD: state_next = ST_ACK;
      ST_ACK, ST_CLEAR_ACK: begin
        if (can_load) begin
          state_next = ST_IDLE;
        end
      end
      ST_OFS_MOD: begin
        if (mod_done) begin
          state_next = ST_ROW_CMD;
        end
      end
      ST_ROW_CMD: begin
        if (can_load) begin
          state_next = ST_ROW_CHARS;
        end
      end
      ST_ROW_CHARS: begin
        if (emit_chr && (left == '0)) begin
          state_next = rf_row ? ST_IDLE : ST_OFS_MOD;
        end
      end
    endcase
  end

  // Outputs and strobes
  logic              out_load;
  logic              o_is_data;
  logic [BYTE_W-1:0] o_byte;
  logic              o_prev;
  logic              o_emit;
  logic              o_last;

  always_comb begin
    mod_start    = 1'b0;
    mod_dividend = req.column;
    mod_divisor  = req.row_sel ? len1 : len0;
    c_we         = 1'b0;
    b_we         = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = chr_addr;
    out_load     = 1'b0;
    o_is_data    = 1'b0;
    o_byte       = '0;
    o_prev       = 1'b0;
    o_emit       = 1'b0;
    o_last       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          unique case (opcode_t'(req.opcode))
            OP_WRITE_CHAR, OP_SET_BLINK: mod_start = 1'b1;
            OP_REFRESH: begin
              mod_start    = 1'b1;
              mod_dividend = COL_W'(offset0);
              mod_divisor  = len0;
            end
            OP_CLEAR: ;
          endcase
        end
      end
      ST_COL_MOD: begin
        rd_addr = col_addr;
        if (mod_done) begin
          c_we  = (op == OP_WRITE_CHAR);
          rd_en = (op != OP_WRITE_CHAR);
        end
      end
      ST_BLINK_RD: b_we = 1'b1;
      ST_ACK: begin
        out_load = can_load;
        o_prev   = (op == OP_SET_BLINK) ? prev_q : 1'b0;
        o_last   = 1'b1;
      end
      ST_CLEAR_ACK: begin
        out_load = can_load;
        o_byte   = CMD_CLEAR;
        o_emit   = 1'b1;
        o_last   = 1'b1;
      end
      ST_OFS_MOD: ;
      ST_ROW_CMD: begin
        out_load = can_load;
        o_byte   = rf_row ? CMD_ROW1 : CMD_ROW0;
        o_emit   = 1'b1;
      end
      ST_ROW_CHARS: begin
        out_load  = emit_chr;
        o_is_data = 1'b1;
        o_byte    = shown;
        o_emit    = 1'b1;
        o_last    = rf_row && (left == '0);
        // keep one read ahead of the output register
        rd_en     = (left != '0) && (!pend || can_load);
        if (emit_chr && (left == '0) && !rf_row) begin
          mod_start    = 1'b1;
          mod_dividend = COL_W'(offset1);
          mod_divisor  = len1;
        end
      end
    endcase
  end

  // Sequencer and cell bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      phase   <= 2'd0;
      offset0 <= '0;
      offset1 <= '0;
      vchar   <= '0;
      vblink  <= '0;
      pend    <= 1'b0;
      rf_row  <= 1'b0;
      left    <= '0;
    end else begin
      state <= state_next;

      if (accept) begin
        op        <= opcode_t'(req.opcode);
        row       <= req.row_sel;
        code      <= req.char_code;
        blink_val <= req.blink_on;
        rf_row    <= 1'b0;
        if (opcode_t'(req.opcode) == OP_REFRESH) begin
          phase <= phase + 2'd1;
        end
        if (opcode_t'(req.opcode) == OP_CLEAR) begin
          vchar   <= '0;
          vblink  <= '0;
          offset0 <= '0;
          offset1 <= '0;
        end
      end

      if (c_we) begin
        vchar[col_addr] <= 1'b1;
      end

      // read-modify-write of the blink mark: old mark captured, new one written
      if (b_we) begin
        prev_q           <= vblink[col_addr] & b_rdata;
        vblink[col_addr] <= 1'b1;
      end

      if (rd_en) begin
        cvld_q <= vchar[rd_addr];
        bvld_q <= vblink[rd_addr];
      end

      // row start: reduced offset is the first cell; scroll on even phases
      if ((state == ST_OFS_MOD) && mod_done) begin
        idx  <= mod_rem[CW-1:0];
        left <= cur_len;
        pend <= 1'b0;
        if (!phase[0] && cur_scroll) begin
          if (rf_row) begin
            offset1 <= next_cell(mod_rem[CW-1:0], cur_len);
          end else begin
            offset0 <= next_cell(mod_rem[CW-1:0], cur_len);
          end
        end
      end

      if (state == ST_ROW_CHARS) begin
        if (rd_en) begin
          idx  <= next_cell(idx, cur_len);
          left <= left - LW'(1);
          pend <= 1'b1;
        end else if (emit_chr) begin
          pend <= 1'b0;
        end
        if (emit_chr && (left == '0) && !rf_row) begin
          rf_row <= 1'b1;
        end
      end
    end
  end

  // Output register: loads when empty or when the current transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_is_data <= o_is_data;
      out_byte_q  <= o_byte;
      out_prev    <= o_prev;
      out_emit    <= o_emit;
      out_last    <= o_last;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.is_data    = out_is_data;
  assign rsp.out_byte   = out_byte_q;
  assign rsp.prev_blink = out_prev;
  assign rsp.emit_valid = out_emit;
  assign rsp.last       = out_last;

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlr_pkg::*;

  localparam int MAX_CELLS = 16;
  // Quiet cycles before a register write
  localparam int SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    opcode_t           op;
    logic              row;
    logic [COL_W-1:0]  col;
    logic [BYTE_W-1:0] code;
    logic              blink;
  } lcd_op_t;

  typedef struct packed {
    logic              is_data;
    logic [BYTE_W-1:0] out_byte;
    logic              prev_blink;
    logic              emit_valid;
    logic              last;
  } lcd_out_t;

  // One line of the directed table: a register write or an operation
  typedef struct {
    bit               is_cfg;
    cfg_reg_t         reg_idx;
    logic [LEN_W-1:0] reg_val;
    lcd_op_t          op;
    bit               typed;
    lcd_out_t         want;
  } plan_row_t;

  localparam lcd_out_t WANT_ACK        = '{1'b0, 8'h00, 1'b0, 1'b0, 1'b1};
  localparam lcd_out_t WANT_ACK_MARKED = '{1'b0, 8'h00, 1'b1, 1'b0, 1'b1};
  localparam lcd_out_t WANT_CLEAR      = '{1'b0, CMD_CLEAR, 1'b0, 1'b1, 1'b1};

  logic clk = 1'b0;
  logic rst;
  logic wr_en;
  cfg_reg_t wr_index;
  logic [LEN_W-1:0] wr_data;

  tlr_req_if req_ch();
  tlr_rsp_if rsp_ch();

  text_line_refresh_with_blink_scroll #(
    .MAX_ROW_CELLS(MAX_CELLS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // Shadow of the display state
  logic [BYTE_W-1:0] char_mem [2*MAX_CELLS];
  logic              blink_mem [2*MAX_CELLS];
  logic [3:0]        row_ofs [2];
  logic [1:0]        blink_phase;
  logic [LEN_W-1:0]  len_cfg [2];
  logic              scroll_cfg [2];

  lcd_out_t    lcd_out_q [$];
  plan_row_t   plan [$];
  int          fail_count = 0;
  int unsigned cycle_count = 0;
  int          send_idle;
  int          recv_idle;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lcd_out_t mk_out(logic d, logic [BYTE_W-1:0] b, logic p, logic v, logic l);
    lcd_out_t o;
    o.is_data    = d;
    o.out_byte   = b;
    o.prev_blink = p;
    o.emit_valid = v;
    o.last       = l;
    return o;
  endfunction

  function automatic int unsigned row_cells(int r);
    int unsigned n;
    n = len_cfg[r];
    if (n < 1) n = 1;
    if (n > MAX_CELLS) n = MAX_CELLS;
    return n;
  endfunction

  function automatic void clear_cells();
    for (int j = 0; j < 2*MAX_CELLS; j++) begin
      char_mem[j]  = CHAR_SPACE;
      blink_mem[j] = 1'b0;
    end
    row_ofs[0] = '0;
    row_ofs[1] = '0;
  endfunction

  // Apply one operation to the shadow state; queue its display bytes when asked
  function automatic void model_lcd_op(lcd_op_t op, bit push_en);
    int unsigned slot, n0, n1, n, total, k, idx;
    logic [BYTE_W-1:0] ch;
    lcd_out_t res;
    case (op.op)
      OP_WRITE_CHAR: begin
        slot = (op.row ? MAX_CELLS : 0) + int'(op.col) % row_cells(op.row);
        char_mem[slot] = op.code;
        if (push_en) lcd_out_q.push_back(mk_out(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
      end
      OP_SET_BLINK: begin
        slot = (op.row ? MAX_CELLS : 0) + int'(op.col) % row_cells(op.row);
        res = mk_out(1'b0, 8'h00, blink_mem[slot], 1'b0, 1'b1);
        blink_mem[slot] = op.blink;
        if (push_en) lcd_out_q.push_back(res);
      end
      OP_CLEAR: begin
        clear_cells();
        if (push_en) lcd_out_q.push_back(mk_out(1'b0, CMD_CLEAR, 1'b0, 1'b1, 1'b1));
      end
      OP_REFRESH: begin
        n0 = row_cells(0);
        n1 = row_cells(1);
        total = 2 + n0 + n1;
        k = 0;
        blink_phase = blink_phase + 2'd1;
        for (int r = 0; r < 2; r++) begin
          n = r ? n1 : n0;
          lcd_out_q.push_back(mk_out(1'b0, r ? CMD_ROW1 : CMD_ROW0, 1'b0, 1'b1, k + 1 == total));
          k++;
          for (int unsigned i = 0; i < n; i++) begin
            idx  = (i + row_ofs[r]) % n;
            slot = r * MAX_CELLS + idx;
            ch   = char_mem[slot];
            if (blink_mem[slot] && blink_phase != 2'd0) ch = CHAR_SPACE;
            lcd_out_q.push_back(mk_out(1'b1, ch, 1'b0, 1'b1, k + 1 == total));
            k++;
          end
        end
        // scroll on even phases, after the bytes went out
        if (!blink_phase[0]) begin
          if (scroll_cfg[0]) row_ofs[0] = 4'((row_ofs[0] + 1) % n0);
          if (scroll_cfg[1]) row_ofs[1] = 4'((row_ofs[1] + 1) % n1);
        end
      end
    endcase
  endfunction

  function automatic plan_row_t op_row(opcode_t op, logic r, logic [COL_W-1:0] col,
                                       logic [BYTE_W-1:0] code, logic blink);
    plan_row_t p;
    p.is_cfg  = 1'b0;
    p.reg_idx = REG_ROW0_LENGTH;
    p.reg_val = '0;
    p.op      = '{op, r, col, code, blink};
    p.typed   = 1'b0;
    p.want    = '0;
    return p;
  endfunction

  function automatic plan_row_t ack_row(opcode_t op, logic r, logic [COL_W-1:0] col,
                                        logic [BYTE_W-1:0] code, logic blink, lcd_out_t want);
    plan_row_t p;
    p       = op_row(op, r, col, code, blink);
    p.typed = 1'b1;
    p.want  = want;
    return p;
  endfunction

  function automatic plan_row_t cfg_row(cfg_reg_t idx, logic [LEN_W-1:0] val);
    plan_row_t p;
    p         = op_row(OP_REFRESH, 1'b0, '0, '0, 1'b0);
    p.is_cfg  = 1'b1;
    p.reg_idx = idx;
    p.reg_val = val;
    return p;
  endfunction

  function automatic lcd_op_t rand_op();
    lcd_op_t o;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35)      o.op = OP_WRITE_CHAR;
    else if (pick < 60) o.op = OP_SET_BLINK;
    else if (pick < 90) o.op = OP_REFRESH;
    else                o.op = OP_CLEAR;
    o.row   = 1'($urandom_range(0, 1));
    o.col   = COL_W'($urandom_range(0, 255));
    o.code  = BYTE_W'($urandom_range(0, 255));
    o.blink = 1'($urandom_range(0, 1));
    return o;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      fail_count++;
    end
  endfunction

  // Offer one operation, hold it until the transfer, then predict
  task automatic send_op(lcd_op_t op, bit typed, lcd_out_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.opcode    = op.op;
    req_ch.row_sel   = op.row;
    req_ch.column    = op.col;
    req_ch.char_code = op.code;
    req_ch.blink_on  = op.blink;
    req_ch.valid     = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    model_lcd_op(op, !typed);
    if (typed) lcd_out_q.push_back(want);
  endtask

  // Stop offering and let every expected byte come out
  task automatic wait_drained();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (lcd_out_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [LEN_W-1:0] val);
    @(negedge clk);
    wr_en    = 1'b1;
    wr_index = idx;
    wr_data  = val;
    @(posedge clk);
    case (idx)
      REG_ROW0_LENGTH: len_cfg[0]    = val;
      REG_ROW1_LENGTH: len_cfg[1]    = val;
      REG_ROW0_SCROLL: scroll_cfg[0] = val[0];
      REG_ROW1_SCROLL: scroll_cfg[1] = val[0];
    endcase
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic apply_cfg(int l0, int l1, int s0, int s1);
    wait_drained();
    write_reg(REG_ROW0_LENGTH, LEN_W'(l0));
    write_reg(REG_ROW1_LENGTH, LEN_W'(l1));
    write_reg(REG_ROW0_SCROLL, LEN_W'(s0));
    write_reg(REG_ROW1_SCROLL, LEN_W'(s1));
  endtask

  // Receiver backpressure
  always @(negedge clk) begin
    rsp_ch.ready = ($urandom_range(0, 99) >= recv_idle);
  end

  // Watchdog and result checking
  always @(posedge clk) begin
    lcd_out_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (lcd_out_q.size() == 0) begin
        $error("unexpected transfer: out_byte 0x%0h is_data %0b", rsp_ch.out_byte,
               rsp_ch.is_data);
        fail_count++;
      end else begin
        want = lcd_out_q.pop_front();
        check_field("is_data", want.is_data, rsp_ch.is_data);
        check_field("out_byte", want.out_byte, rsp_ch.out_byte);
        check_field("prev_blink", want.prev_blink, rsp_ch.prev_blink);
        check_field("emit_valid", want.emit_valid, rsp_ch.emit_valid);
        check_field("last", want.last, rsp_ch.last);
      end
    end
  end

  initial begin
    rst              = 1'b1;
    wr_en            = 1'b0;
    wr_index         = REG_ROW0_LENGTH;
    wr_data          = '0;
    req_ch.valid     = 1'b0;
    req_ch.opcode    = OP_WRITE_CHAR;
    req_ch.row_sel   = 1'b0;
    req_ch.column    = '0;
    req_ch.char_code = '0;
    req_ch.blink_on  = 1'b0;
    rsp_ch.ready     = 1'b0;
    send_idle        = 31;
    recv_idle        = 68;

    clear_cells();
    blink_phase   = 2'd0;
    len_cfg[0]    = LEN_RESET;
    len_cfg[1]    = LEN_RESET;
    scroll_cfg[0] = 1'b0;
    scroll_cfg[1] = 1'b0;

    // Directed part
    plan.push_back(op_row(OP_REFRESH, 1'b0, 8'h00, 8'h00, 1'b0));  // blank screen after reset
    plan.push_back(ack_row(OP_WRITE_CHAR, 1'b0, 8'h00, 8'hFF, 1'b0, WANT_ACK));
    plan.push_back(ack_row(OP_WRITE_CHAR, 1'b1, 8'hFF, 8'h00, 1'b1, WANT_ACK));  // wraps to col 15
    plan.push_back(ack_row(OP_SET_BLINK, 1'b0, 8'h00, 8'h00, 1'b1, WANT_ACK));
    plan.push_back(ack_row(OP_SET_BLINK, 1'b0, 8'h10, 8'hFF, 1'b1, WANT_ACK_MARKED));  // col 16 -> 0
    plan.push_back(ack_row(OP_SET_BLINK, 1'b1, 8'hFF, 8'h00, 1'b1, WANT_ACK));
    // full blink phase cycle: blanked three times, shown on phase 0
    repeat (4) plan.push_back(op_row(OP_REFRESH, 1'b0, 8'h00, 8'h00, 1'b0));
    plan.push_back(cfg_row(REG_ROW0_SCROLL, 5'd1));
    plan.push_back(cfg_row(REG_ROW1_SCROLL, 5'd1));
    plan.push_back(op_row(OP_WRITE_CHAR, 1'b1, 8'h03, 8'h41, 1'b0));
    repeat (3) plan.push_back(op_row(OP_REFRESH, 1'b0, 8'h00, 8'h00, 1'b0));
    // shrink row 0 under a nonzero offset; zero length acts as one, 31 as full
    plan.push_back(cfg_row(REG_ROW0_LENGTH, 5'd0));
    plan.push_back(cfg_row(REG_ROW1_LENGTH, 5'd31));
    plan.push_back(op_row(OP_REFRESH, 1'b0, 8'h00, 8'h00, 1'b0));
    plan.push_back(ack_row(OP_WRITE_CHAR, 1'b0, 8'hC8, 8'h7E, 1'b0, WANT_ACK));
    plan.push_back(ack_row(OP_SET_BLINK, 1'b1, 8'hAA, 8'h00, 1'b0, WANT_ACK));
    plan.push_back(op_row(OP_REFRESH, 1'b0, 8'h00, 8'h00, 1'b0));
    plan.push_back(ack_row(OP_CLEAR, 1'b0, 8'h00, 8'h00, 1'b0, WANT_CLEAR));
    plan.push_back(cfg_row(REG_ROW0_LENGTH, 5'd5));
    plan.push_back(cfg_row(REG_ROW1_LENGTH, 5'd1));
    plan.push_back(cfg_row(REG_ROW0_SCROLL, 5'd0));
    repeat (2) plan.push_back(op_row(OP_REFRESH, 1'b0, 8'h00, 8'h00, 1'b0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        wait_drained();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_op(plan[i].op, plan[i].typed, plan[i].want);
      end
    end

    // Random part: three idling modes, two register settings each
    for (int m = 0; m < 3; m++) begin
      send_idle = (m == 0) ? 31 : (m == 1) ? 68 : 0;
      recv_idle = (m == 0) ? 68 : (m == 1) ? 31 : 0;
      for (int s = 0; s < 2; s++) begin
        case (m * 2 + s)
          0: apply_cfg(7, 12, 1, 1);
          1: apply_cfg(16, 1, 0, 1);
          2: apply_cfg(31, 0, 1, 0);
          3: apply_cfg($urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 1), $urandom_range(0, 1));
          4: apply_cfg(1, 16, 1, 1);
          default: apply_cfg($urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 1), $urandom_range(0, 1));
        endcase
        repeat (17) send_op(rand_op(), 1'b0, '0);
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
